### hw/rtl/gaps_pkg.sv
`timescale 1ns / 1ps
package gaps_pkg;

    localparam int DIM_W      = 6;
    localparam int CELL_W     = 12;
    localparam int NCELLS     = 4096;
    localparam int COST_W     = 13;
    localparam int PATH_DEPTH = 1025;
    localparam int PIDX_W     = 11;
    localparam int CNT_W      = 13;

    localparam logic [6:0]        GRID_MAX  = 7'd64;
    localparam logic [COST_W-1:0] NO_PARENT = 13'd4096;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_FIND = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_END = 2'd1;
    localparam logic [1:0] STAT_NO_PATH = 2'd2;
    localparam logic [1:0] STAT_RANGE   = 2'd3;

    localparam logic [2:0] CFG_ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_ADDR_HEIGHT = 3'd4;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DIM_W-1:0]  cell_x;
        logic [DIM_W-1:0]  cell_y;
        logic [DIM_W-1:0]  goal_x;
        logic [DIM_W-1:0]  goal_y;
        logic              walkable;
        logic [PIDX_W-1:0] path_index;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PIDX_W-1:0] path_length;
        logic [DIM_W-1:0]  out_x;
        logic [DIM_W-1:0]  out_y;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FIND,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t  op;
        req_t item;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_t;

    typedef struct packed {
        logic [COST_W-1:0] f;
        logic [CELL_W-1:0] loc;
    } heap_ent_t;

    typedef struct packed {
        logic              closed;
        logic              open;
        logic [COST_W-1:0] came;
        logic [COST_W-1:0] g;
        logic [COST_W-1:0] f;
    } node_t;

    typedef enum logic [4:0] {
        S_WCLR,
        S_IDLE,
        S_RD,
        S_F_S,
        S_F_G,
        S_CLR,
        S_INIT,
        S_POP0,
        S_POP1,
        S_POP2,
        S_SD0,
        S_SD1,
        S_SD2,
        S_SD_END,
        S_CUR,
        S_NB0,
        S_NB1,
        S_NB2,
        S_SU0,
        S_SU1,
        S_SU_END,
        S_TR0,
        S_TR1
    } state_t;

    function automatic logic [6:0] dim_clamp(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v == 7'd0)
        begin
            r = 7'd1;
        end
        else if (v > GRID_MAX)
        begin
            r = GRID_MAX;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] absdiff(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [6:0] manhattan(input logic [DIM_W-1:0] ax,
                                             input logic [DIM_W-1:0] ay,
                                             input logic [DIM_W-1:0] bx,
                                             input logic [DIM_W-1:0] by);
        return {1'b0, absdiff(ax, bx)} + {1'b0, absdiff(ay, by)};
    endfunction

endpackage

### hw/rtl/gaps_front.sv
`timescale 1ns / 1ps
module gaps_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  gaps_pkg::req_t  req,
    output gaps_pkg::q_t    q,
    input  logic            q_pop
);

    gaps_pkg::cmd_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    logic           pop;
    gaps_pkg::op_t  op;

    always_comb
    begin
        unique case (req.mode)
            gaps_pkg::MODE_LOAD: op = gaps_pkg::OP_LOAD;
            gaps_pkg::MODE_FIND: op = gaps_pkg::OP_FIND;
            gaps_pkg::MODE_READ: op = gaps_pkg::OP_READ;
            default:             op = gaps_pkg::OP_NOP;
        endcase
    end

    assign req_ready = (count_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign pop       = q_pop && (count_reg != 2'd0);

    assign q.valid = (count_reg != 2'd0);
    assign q.cmd   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{op: op, item: req};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/gaps_engine.sv
`timescale 1ns / 1ps
module gaps_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [6:0]      gw,
    input  logic [6:0]      gh,
    input  gaps_pkg::q_t    q,
    output logic            q_pop,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output gaps_pkg::rsp_t  rsp
);

    localparam int CW = gaps_pkg::CELL_W;
    localparam int KW = gaps_pkg::COST_W;
    localparam int NW = gaps_pkg::CNT_W;
    localparam int PW = gaps_pkg::PIDX_W;

    // storage
    logic                  walk_mem [gaps_pkg::NCELLS];
    gaps_pkg::node_t       node_mem [gaps_pkg::NCELLS];
    gaps_pkg::heap_ent_t   heap_mem [gaps_pkg::NCELLS];
    logic [CW-1:0]         slot_mem [gaps_pkg::NCELLS];
    logic [CW-1:0]         path_mem [gaps_pkg::PATH_DEPTH];

    logic                  walk_rd_reg;
    gaps_pkg::node_t       node_rd_reg;
    gaps_pkg::heap_ent_t   heap_rd_reg;
    logic [CW-1:0]         slot_rd_reg;
    logic [CW-1:0]         path_rd_reg;

    logic                  walk_we;
    logic [CW-1:0]         walk_waddr, walk_raddr;
    logic                  walk_wdata;
    logic                  node_we;
    logic [CW-1:0]         node_waddr, node_raddr;
    gaps_pkg::node_t       node_wdata;
    logic                  heap_we;
    logic [CW-1:0]         heap_waddr, heap_raddr;
    gaps_pkg::heap_ent_t   heap_wdata;
    logic                  slot_we;
    logic [CW-1:0]         slot_waddr, slot_raddr, slot_wdata;
    logic                  path_we;
    logic [PW-1:0]         path_waddr, path_raddr;
    logic [CW-1:0]         path_wdata;

    // control
    gaps_pkg::state_t      state_reg, state_next;
    logic [CW-1:0]         ctr_reg, ctr_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         i_reg, i_next;
    gaps_pkg::heap_ent_t   mv_reg, mv_next;
    gaps_pkg::heap_ent_t   lc_reg, lc_next;
    logic [CW-1:0]         top_reg, top_next;
    logic [KW-1:0]         gcur_reg, gcur_next;
    logic [1:0]            k_reg, k_next;
    logic [CW-1:0]         nc_reg, nc_next;
    logic [PW-1:0]         t_reg, t_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [PW-1:0]         pcount_reg, pcount_next;
    gaps_pkg::req_t        cmd_reg, cmd_next;
    logic                  out_valid_reg, out_valid_next;
    gaps_pkg::rsp_t        out_reg, out_next;

    logic [6:0]            w, h;
    logic [5:0]            cx, cy;
    logic [NW-1:0]         sd_l, sd_r;
    logic [CW-1:0]         su_p;
    logic [KW-1:0]         tg, nb_f;
    logic [6:0]            nb_h, st_h;
    logic                  nb_ok;
    logic [CW-1:0]         nb_cell;
    gaps_pkg::heap_ent_t   sd_child;
    logic [CW-1:0]         sd_s;
    logic                  nb_last;
    gaps_pkg::state_t      after_nb;

    assign w       = gaps_pkg::dim_clamp(gw);
    assign h       = gaps_pkg::dim_clamp(gh);
    assign cx      = top_reg[5:0];
    assign cy      = top_reg[11:6];
    assign sd_l    = {i_reg, 1'b1};
    assign sd_r    = sd_l + {{(NW-1){1'b0}}, 1'b1};
    assign su_p    = (i_reg - {{(CW-1){1'b0}}, 1'b1}) >> 1;
    assign tg      = gcur_reg + {{(KW-1){1'b0}}, 1'b1};
    assign nb_h    = gaps_pkg::manhattan(nc_reg[5:0], nc_reg[11:6],
                                         cmd_reg.goal_x, cmd_reg.goal_y);
    assign nb_f    = tg + {6'd0, nb_h};
    assign st_h    = gaps_pkg::manhattan(cmd_reg.cell_x, cmd_reg.cell_y,
                                         cmd_reg.goal_x, cmd_reg.goal_y);
    assign nb_last = (k_reg == 2'd3);
    assign after_nb = nb_last ? gaps_pkg::S_POP0 : gaps_pkg::S_NB0;

    always_comb
    begin
        nb_ok   = 1'b0;
        nb_cell = top_reg;
        unique case (k_reg)
            2'd0:
            begin
                nb_ok   = ({1'b0, cx} + 7'd1) < w;
                nb_cell = {cy, cx + 6'd1};
            end
            2'd1:
            begin
                nb_ok   = (cx != 6'd0);
                nb_cell = {cy, cx - 6'd1};
            end
            2'd2:
            begin
                nb_ok   = ({1'b0, cy} + 7'd1) < h;
                nb_cell = {cy + 6'd1, cx};
            end
            default:
            begin
                nb_ok   = (cy != 6'd0);
                nb_cell = {cy - 6'd1, cx};
            end
        endcase
    end

    // smaller child for sift-down; right child only seen in S_SD2
    always_comb
    begin
        if (state_reg == gaps_pkg::S_SD2 && heap_rd_reg.f < lc_reg.f)
        begin
            sd_child = heap_rd_reg;
            sd_s     = sd_r[CW-1:0];
        end
        else if (state_reg == gaps_pkg::S_SD2)
        begin
            sd_child = lc_reg;
            sd_s     = sd_l[CW-1:0];
        end
        else
        begin
            sd_child = heap_rd_reg;
            sd_s     = sd_l[CW-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        mv_next        = mv_reg;
        lc_next        = lc_reg;
        top_next       = top_reg;
        gcur_next      = gcur_reg;
        k_next         = k_reg;
        nc_next        = nc_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        pcount_next    = pcount_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;

        walk_we    = 1'b0;
        walk_waddr = ctr_reg;
        walk_wdata = 1'b0;
        walk_raddr = nc_reg;
        node_we    = 1'b0;
        node_waddr = nc_reg;
        node_wdata = node_rd_reg;
        node_raddr = nc_reg;
        heap_we    = 1'b0;
        heap_waddr = i_reg;
        heap_wdata = mv_reg;
        heap_raddr = i_reg;
        slot_we    = 1'b0;
        slot_waddr = mv_reg.loc;
        slot_wdata = i_reg;
        slot_raddr = nc_reg;
        path_we    = 1'b0;
        path_waddr = t_reg;
        path_wdata = idx_reg;
        path_raddr = pcount_reg - {{(PW-1){1'b0}}, 1'b1} - cmd_reg.path_index;

        unique case (state_reg)
            gaps_pkg::S_WCLR:
            begin
                walk_we  = 1'b1;
                ctr_next = ctr_reg + {{(CW-1){1'b0}}, 1'b1};
                if (ctr_reg == {CW{1'b1}})
                begin
                    state_next = gaps_pkg::S_IDLE;
                end
            end

            gaps_pkg::S_IDLE:
            begin
                if (q.valid && !out_valid_reg)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q.cmd.item;
                    out_next = '{status: gaps_pkg::STAT_OK, path_length: pcount_reg,
                                 out_x: '0, out_y: '0};
                    unique case (q.cmd.op)
                        gaps_pkg::OP_LOAD:
                        begin
                            walk_we        = 1'b1;
                            walk_waddr     = {q.cmd.item.cell_y, q.cmd.item.cell_x};
                            walk_wdata     = q.cmd.item.walkable;
                            out_valid_next = 1'b1;
                        end
                        gaps_pkg::OP_FIND:
                        begin
                            pcount_next = '0;
                            walk_raddr  = {q.cmd.item.cell_y, q.cmd.item.cell_x};
                            if ({1'b0, q.cmd.item.cell_x} >= w
                                || {1'b0, q.cmd.item.cell_y} >= h
                                || {1'b0, q.cmd.item.goal_x} >= w
                                || {1'b0, q.cmd.item.goal_y} >= h)
                            begin
                                out_next       = '{status: gaps_pkg::STAT_BAD_END,
                                                   path_length: '0, out_x: '0, out_y: '0};
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = gaps_pkg::S_F_S;
                            end
                        end
                        gaps_pkg::OP_READ:
                        begin
                            path_raddr = pcount_reg - {{(PW-1){1'b0}}, 1'b1}
                                         - q.cmd.item.path_index;
                            if (q.cmd.item.path_index < pcount_reg)
                            begin
                                state_next = gaps_pkg::S_RD;
                            end
                            else
                            begin
                                out_next.status = gaps_pkg::STAT_RANGE;
                                out_valid_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            gaps_pkg::S_RD:
            begin
                out_next.out_x = path_rd_reg[5:0];
                out_next.out_y = path_rd_reg[11:6];
                out_valid_next = 1'b1;
                state_next     = gaps_pkg::S_IDLE;
            end

            gaps_pkg::S_F_S:
            begin
                walk_raddr = {cmd_reg.goal_y, cmd_reg.goal_x};
                if (!walk_rd_reg)
                begin
                    out_next       = '{status: gaps_pkg::STAT_BAD_END,
                                       path_length: '0, out_x: '0, out_y: '0};
                    out_valid_next = 1'b1;
                    state_next     = gaps_pkg::S_IDLE;
                end
                else
                begin
                    state_next = gaps_pkg::S_F_G;
                end
            end

            gaps_pkg::S_F_G:
            begin
                ctr_next = '0;
                if (!walk_rd_reg)
                begin
                    out_next       = '{status: gaps_pkg::STAT_BAD_END,
                                       path_length: '0, out_x: '0, out_y: '0};
                    out_valid_next = 1'b1;
                    state_next     = gaps_pkg::S_IDLE;
                end
                else
                begin
                    state_next = gaps_pkg::S_CLR;
                end
            end

            gaps_pkg::S_CLR:
            begin
                node_we    = 1'b1;
                node_waddr = ctr_reg;
                node_wdata = '{closed: 1'b0, open: 1'b0, came: gaps_pkg::NO_PARENT,
                               g: '0, f: '0};
                ctr_next   = ctr_reg + {{(CW-1){1'b0}}, 1'b1};
                if (ctr_reg == {CW{1'b1}})
                begin
                    state_next = gaps_pkg::S_INIT;
                end
            end

            gaps_pkg::S_INIT:
            begin
                node_we    = 1'b1;
                node_waddr = {cmd_reg.cell_y, cmd_reg.cell_x};
                node_wdata = '{closed: 1'b0, open: 1'b1, came: gaps_pkg::NO_PARENT,
                               g: '0, f: {6'd0, st_h}};
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = '{f: {6'd0, st_h}, loc: {cmd_reg.cell_y, cmd_reg.cell_x}};
                slot_we    = 1'b1;
                slot_waddr = {cmd_reg.cell_y, cmd_reg.cell_x};
                slot_wdata = '0;
                cnt_next   = {{(NW-1){1'b0}}, 1'b1};
                state_next = gaps_pkg::S_POP0;
            end

            gaps_pkg::S_POP0:
            begin
                heap_raddr = '0;
                if (cnt_reg == '0)
                begin
                    out_next       = '{status: gaps_pkg::STAT_NO_PATH,
                                       path_length: '0, out_x: '0, out_y: '0};
                    out_valid_next = 1'b1;
                    state_next     = gaps_pkg::S_IDLE;
                end
                else
                begin
                    state_next = gaps_pkg::S_POP1;
                end
            end

            gaps_pkg::S_POP1:
            begin
                top_next   = heap_rd_reg.loc;
                heap_raddr = cnt_reg[CW-1:0] - {{(CW-1){1'b0}}, 1'b1};
                state_next = gaps_pkg::S_POP2;
            end

            gaps_pkg::S_POP2:
            begin
                mv_next    = heap_rd_reg;
                cnt_next   = cnt_reg - {{(NW-1){1'b0}}, 1'b1};
                i_next     = '0;
                state_next = gaps_pkg::S_SD0;
            end

            gaps_pkg::S_SD0:
            begin
                heap_raddr = sd_l[CW-1:0];
                if (sd_l >= cnt_reg)
                begin
                    state_next = gaps_pkg::S_SD_END;
                end
                else
                begin
                    state_next = gaps_pkg::S_SD1;
                end
            end

            gaps_pkg::S_SD1, gaps_pkg::S_SD2:
            begin
                lc_next    = heap_rd_reg;
                heap_raddr = sd_r[CW-1:0];
                if (state_reg == gaps_pkg::S_SD1 && sd_r < cnt_reg)
                begin
                    state_next = gaps_pkg::S_SD2;
                end
                else if (mv_reg.f <= sd_child.f)
                begin
                    state_next = gaps_pkg::S_SD_END;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_waddr = i_reg;
                    heap_wdata = sd_child;
                    slot_we    = 1'b1;
                    slot_waddr = sd_child.loc;
                    slot_wdata = i_reg;
                    i_next     = sd_s;
                    state_next = gaps_pkg::S_SD0;
                end
            end

            gaps_pkg::S_SD_END:
            begin
                heap_we    = 1'b1;
                slot_we    = 1'b1;
                node_raddr = top_reg;
                state_next = gaps_pkg::S_CUR;
            end

            gaps_pkg::S_CUR:
            begin
                gcur_next         = node_rd_reg.g;
                node_we           = 1'b1;
                node_waddr        = top_reg;
                node_wdata.open   = 1'b0;
                node_wdata.closed = 1'b1;
                k_next            = 2'd0;
                idx_next          = top_reg;
                t_next            = '0;
                if (top_reg == {cmd_reg.goal_y, cmd_reg.goal_x})
                begin
                    state_next = gaps_pkg::S_TR0;
                end
                else
                begin
                    state_next = gaps_pkg::S_NB0;
                end
            end

            gaps_pkg::S_NB0:
            begin
                nc_next    = nb_cell;
                walk_raddr = nb_cell;
                node_raddr = nb_cell;
                if (nb_ok)
                begin
                    state_next = gaps_pkg::S_NB1;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = after_nb;
                end
            end

            gaps_pkg::S_NB1:
            begin
                if (walk_rd_reg && !node_rd_reg.closed
                    && (!node_rd_reg.open || tg < node_rd_reg.g))
                begin
                    node_we    = 1'b1;
                    node_waddr = nc_reg;
                    node_wdata = '{closed: 1'b0, open: 1'b1, came: {1'b0, top_reg},
                                   g: tg, f: nb_f};
                    mv_next    = '{f: nb_f, loc: nc_reg};
                    slot_raddr = nc_reg;
                    if (!node_rd_reg.open)
                    begin
                        i_next     = cnt_reg[CW-1:0];
                        cnt_next   = cnt_reg + {{(NW-1){1'b0}}, 1'b1};
                        state_next = gaps_pkg::S_SU0;
                    end
                    else
                    begin
                        state_next = gaps_pkg::S_NB2;
                    end
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = after_nb;
                end
            end

            gaps_pkg::S_NB2:
            begin
                i_next     = slot_rd_reg;
                state_next = gaps_pkg::S_SU0;
            end

            gaps_pkg::S_SU0:
            begin
                heap_raddr = su_p;
                if (i_reg == '0)
                begin
                    state_next = gaps_pkg::S_SU_END;
                end
                else
                begin
                    state_next = gaps_pkg::S_SU1;
                end
            end

            gaps_pkg::S_SU1:
            begin
                if (heap_rd_reg.f <= mv_reg.f)
                begin
                    state_next = gaps_pkg::S_SU_END;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_waddr = i_reg;
                    heap_wdata = heap_rd_reg;
                    slot_we    = 1'b1;
                    slot_waddr = heap_rd_reg.loc;
                    slot_wdata = i_reg;
                    i_next     = su_p;
                    state_next = gaps_pkg::S_SU0;
                end
            end

            gaps_pkg::S_SU_END:
            begin
                heap_we    = 1'b1;
                slot_we    = 1'b1;
                k_next     = k_reg + 2'd1;
                state_next = after_nb;
            end

            gaps_pkg::S_TR0:
            begin
                path_we    = 1'b1;
                node_raddr = idx_reg;
                state_next = gaps_pkg::S_TR1;
            end

            gaps_pkg::S_TR1:
            begin
                t_next   = t_reg + {{(PW-1){1'b0}}, 1'b1};
                idx_next = node_rd_reg.came[CW-1:0];
                if (node_rd_reg.came[CW]
                    || t_next >= PW'(gaps_pkg::PATH_DEPTH))
                begin
                    pcount_next    = t_next;
                    out_next       = '{status: gaps_pkg::STAT_OK, path_length: t_next,
                                       out_x: '0, out_y: '0};
                    out_valid_next = 1'b1;
                    state_next     = gaps_pkg::S_IDLE;
                end
                else
                begin
                    state_next = gaps_pkg::S_TR0;
                end
            end

            default:
            begin
                state_next = gaps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (walk_we)
        begin
            walk_mem[walk_waddr] <= walk_wdata;
        end
        walk_rd_reg <= walk_mem[walk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd_reg <= heap_mem[heap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_waddr] <= path_wdata;
        end
        path_rd_reg <= path_mem[path_raddr];
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        i_reg    <= i_next;
        mv_reg   <= mv_next;
        lc_reg   <= lc_next;
        top_reg  <= top_next;
        gcur_reg <= gcur_next;
        k_reg    <= k_next;
        nc_reg   <= nc_next;
        t_reg    <= t_next;
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gaps_pkg::S_WCLR;
            ctr_reg       <= '0;
            pcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            pcount_reg    <= pcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### hw/rtl/grid_astar_path_search_top.sv
`timescale 1ns / 1ps
// A* path search on a 4-connected grid of up to 64 x 64 cells.
// req channel (valid/ready): one beat per command. mode selects load of a
// walkability bit, find of a path from (cell_x, cell_y) to (goal_x, goal_y),
// or read of one path cell by path_index. rsp channel (valid/ready): exactly
// one beat per command, in command order.
// APB port: grid_width at 0x0, grid_height at 0x4; write only while idle.
// Load and the unused mode respond in the cycle after the engine picks the
// command up; a read first goes through the path memory, and a rejected find
// may first check the start and goal cells. An accepted find sweeps all 4096
// node memory entries, then expands cells at a cost that grows with heap
// depth, as each heap sift step and neighbor probe is an access to node, heap
// and slot memories with one read and one write port; then traces the path.
// Throughput: one command in the engine at a time; a 2-entry command queue
// keeps accepting until full while the engine or the rsp register is busy.
// Reset: all 4096 cells of the walkability map are swept to blocked, during
// which commands queue but are not processed; stored path length goes to 0.
// A stalled rsp holds its beat; the engine starts no command until the
// rsp register has been taken.
module grid_astar_path_search_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic            req_valid,
    output logic            req_ready,
    input  gaps_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output gaps_pkg::rsp_t  rsp
);

    logic [6:0]   gw_reg, gw_next;
    logic [6:0]   gh_reg, gh_next;
    logic         cfg_wr;
    gaps_pkg::q_t q;
    logic         q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        gw_next = gw_reg;
        gh_next = gh_reg;
        if (cfg_wr && !paddr[2])
        begin
            gw_next = pwdata[6:0];
        end
        if (cfg_wr && paddr[2])
        begin
            gh_next = pwdata[6:0];
        end
    end

    always_comb
    begin
        priority if (paddr == gaps_pkg::CFG_ADDR_HEIGHT)
        begin
            prdata = {25'd0, gh_reg};
        end
        else if (paddr == gaps_pkg::CFG_ADDR_WIDTH)
        begin
            prdata = {25'd0, gw_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= gaps_pkg::GRID_MAX;
            gh_reg <= gaps_pkg::GRID_MAX;
        end
        else
        begin
            gw_reg <= gw_next;
            gh_reg <= gh_next;
        end
    end

    gaps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q         (q),
        .q_pop     (q_pop)
    );

    gaps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .gw        (gw_reg),
        .gh        (gh_reg),
        .q         (q),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### hw/rtl/gaps_chk.sv
`timescale 1ns / 1ps
module gaps_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input gaps_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp beat changed while stalled");

    a_fail_no_path: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == gaps_pkg::STAT_BAD_END
                      || rsp.status == gaps_pkg::STAT_NO_PATH)
        |-> rsp.path_length == '0)
        else $error("failed find left a path length");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == gaps_pkg::STAT_RANGE
        |-> rsp.out_x == '0 && rsp.out_y == '0)
        else $error("out of range read returned a cell");

    a_cell_needs_path: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.out_x != '0 || rsp.out_y != '0)
        |-> rsp.path_length != '0 && rsp.status == gaps_pkg::STAT_OK)
        else $error("cell returned without stored path");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.path_length <= 11'(gaps_pkg::PATH_DEPTH))
        else $error("path length above store depth");

endmodule

bind grid_astar_path_search_top gaps_chk u_chk (.*);
